/* hw/rtl/dsrt_pkg.sv */
// ----------------------------------------------------------------------------
// Downstream record table package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dsrt_pkg;

	// default slot count
	localparam int DN_SLOTS_DEF = 16;

	// field widths
	localparam int FACE_W = 16;
	localparam int NONCE_W = 32;
	localparam int TIME_W = 62;
	localparam int TOKEN_W = 64;
	localparam int MARK_W = 8;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// register reset values
	localparam logic [CFG_W-1:0] MAX_LIFE_RST = 32'd120000;
	localparam logic [CFG_W-1:0] TICKS_RST = 32'd1000000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LIFE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS = 2'd1;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_NEW = 3'd0;
	localparam logic [2:0] ST_REFRESH = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_NODUP = 3'd3;
	localparam logic [2:0] ST_DUP = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	// slot walk outcome
	localparam logic [2:0] K_FIRST = 3'd0;
	localparam logic [2:0] K_REFRESH = 3'd1;
	localparam logic [2:0] K_EMPTY = 3'd2;
	localparam logic [2:0] K_EXPIRED = 3'd3;
	localparam logic [2:0] K_NODUP = 3'd4;
	localparam logic [2:0] K_DUP = 3'd5;

	// stored record of one slot
	typedef struct packed {
		logic [NONCE_W-1:0] nonce;
		logic [TIME_W-1:0]  expiry;
		logic               prefix;
		logic [TOKEN_W-1:0] token;
		logic [MARK_W-1:0]  mark;
	} slot_rec_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cmd_walk;
		logic cmd_clear;
		logic cmd_none;
		logic hit;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

/* hw/rtl/dsrt_ctrl.sv */
// ----------------------------------------------------------------------------
// Downstream record table controller
// Sequences request capture, slot walk and result commit.
// ----------------------------------------------------------------------------
module dsrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dsrt_pkg::dp_stat_t stat,
	output dsrt_pkg::dp_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (stat.cmd_none) begin
					state_d = S_IDLE;
				end else if (stat.cmd_clear) begin
					state_d = S_COMMIT;
				end else begin
					cmd.step = 1'b1;
					if (stat.hit || stat.last) state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

/* hw/rtl/dsrt_dp.sv */
// ----------------------------------------------------------------------------
// Downstream record table datapath
// Slot storage, walk compare, expiry arithmetic, entry state and outputs.
// ----------------------------------------------------------------------------
module dsrt_dp #(
	parameter int DN_SLOTS = dsrt_pkg::DN_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dsrt_pkg::dp_cmd_t                   cmd,
	output dsrt_pkg::dp_stat_t                  stat,
	input  logic                                cfg_valid,
	input  logic [dsrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dsrt_pkg::CFG_W-1:0]          cfg_data,
	input  logic [1:0]                          cmd_in,
	input  logic [dsrt_pkg::FACE_W-1:0]         face,
	input  logic [dsrt_pkg::NONCE_W-1:0]        nonce,
	input  logic                                can_be_prefix,
	input  logic [31:0]                         lifetime_ms,
	input  logic [7:0]                          hop_limit,
	input  logic [dsrt_pkg::TIME_W-1:0]         now_ticks,
	input  logic [dsrt_pkg::TOKEN_W-1:0]        token,
	input  logic [dsrt_pkg::MARK_W-1:0]         cong_mark,
	input  logic                                first_interest,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          status,
	output logic [3:0]                          slot_index,
	output logic [dsrt_pkg::FACE_W-1:0]         dup_face,
	output logic [dsrt_pkg::TIME_W-1:0]         record_expiry,
	output logic [dsrt_pkg::TIME_W-1:0]         entry_expiry,
	output logic                                timer_rearm,
	output logic                                take_as_representative,
	output logic [7:0]                          tx_hop_limit,
	output logic [7:0]                          prefix_count
);

	localparam int IW = (DN_SLOTS > 1) ? $clog2(DN_SLOTS) : 1;
	localparam int FW = dsrt_pkg::FACE_W;
	localparam int TW = dsrt_pkg::TIME_W;

	// configuration registers
	logic [31:0] max_life_q, ticks_q;

	// captured request
	logic [1:0]    cmd_q;
	logic [FW-1:0] face_in_q;
	logic [31:0]   nonce_q;
	logic          cbp_q, first_q;
	logic [7:0]    hop_in_q;
	logic [TW-1:0] now_q;
	logic [63:0]   token_q;
	logic [7:0]    mark_q;

	// walk and arithmetic state
	logic [IW-1:0] idx_q, idx_d;
	logic          found_q;
	logic [2:0]    kind_q;
	logic [63:0]   dur_q;
	logic [TW-1:0] rec_q;

	// slot storage
	logic [FW-1:0]       face_q [DN_SLOTS];
	dsrt_pkg::slot_rec_t mem_q [DN_SLOTS];
	dsrt_pkg::slot_rec_t rd_q;

	// entry state
	logic [7:0]    count_q, hop_q;
	logic [TW-1:0] whole_q;

	// walk compare
	logic [FW-1:0] cur_face;
	logic          is_empty, is_match, is_exp, hit;
	logic [2:0]    kind;
	logic [31:0]   lt;
	logic [64:0]   sum;

	// commit arithmetic
	logic [7:0]    cnt_base, cnt_new;
	logic [7:0]    hop_dec;
	logic          take;

	assign cur_face = face_q[idx_q];
	assign is_empty = (cur_face == '0);
	assign is_match = (cur_face == face_in_q);
	assign is_exp = (rd_q.expiry < now_q);

	// classify the current slot
	always_comb begin
		hit = 1'b0;
		kind = dsrt_pkg::K_NODUP;
		if (cmd_q == dsrt_pkg::CMD_INSERT) begin
			hit = 1'b1;
			if (idx_q == '0 && is_empty) kind = dsrt_pkg::K_FIRST;
			else if (is_match) kind = dsrt_pkg::K_REFRESH;
			else if (is_empty) kind = dsrt_pkg::K_EMPTY;
			else if (is_exp) kind = dsrt_pkg::K_EXPIRED;
			else hit = 1'b0;
		end else begin
			if (is_empty) begin
				hit = 1'b1;
				kind = dsrt_pkg::K_NODUP;
			end else if (!is_match && rd_q.nonce == nonce_q) begin
				hit = 1'b1;
				kind = dsrt_pkg::K_DUP;
			end
		end
	end

	assign stat.cmd_walk = (cmd_q == dsrt_pkg::CMD_INSERT) || (cmd_q == dsrt_pkg::CMD_DUP);
	assign stat.cmd_clear = (cmd_q == dsrt_pkg::CMD_CLEAR);
	assign stat.cmd_none = !stat.cmd_walk && !stat.cmd_clear;
	assign stat.hit = hit;
	assign stat.last = (idx_q == IW'(DN_SLOTS - 1));
	assign stat.out_free = !out_valid || out_ready;

	// next walk index also addresses the record read
	always_comb begin
		idx_d = idx_q;
		if (cmd.load) idx_d = '0;
		else if (cmd.step && !hit && !stat.last) idx_d = idx_q + IW'(1);
	end

	// clamp lifetime for the duration product
	assign lt = (lifetime_ms < max_life_q) ? lifetime_ms : max_life_q;
	assign sum = {3'b0, now_q} + {1'b0, dur_q};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_life_q <= dsrt_pkg::MAX_LIFE_RST;
			ticks_q <= dsrt_pkg::TICKS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == dsrt_pkg::REG_MAX_LIFE) max_life_q <= cfg_data;
			else if (cfg_index == dsrt_pkg::REG_TICKS) ticks_q <= cfg_data;
		end
	end

	// capture request, multiply, saturate expiry
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= cmd_in;
			face_in_q <= face;
			nonce_q <= nonce;
			cbp_q <= can_be_prefix;
			first_q <= first_interest;
			hop_in_q <= hop_limit;
			now_q <= now_ticks;
			token_q <= token;
			mark_q <= cong_mark;
			dur_q <= 64'(lt) * 64'(ticks_q);
		end
		rec_q <= (sum > {3'b0, dsrt_pkg::TIME_MAX}) ? dsrt_pkg::TIME_MAX : sum[TW-1:0];
	end

	// walk position and outcome
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			found_q <= 1'b0;
			kind_q <= dsrt_pkg::K_NODUP;
		end else begin
			idx_q <= idx_d;
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.step && hit) begin
				found_q <= 1'b1;
				kind_q <= kind;
			end
		end
	end

	// record memory
	always_ff @(posedge clk) begin
		rd_q <= mem_q[idx_d];
		if (cmd.commit && cmd_q == dsrt_pkg::CMD_INSERT && found_q) begin
			mem_q[idx_q] <= '{nonce: nonce_q, expiry: rec_q, prefix: cbp_q,
				token: token_q, mark: mark_q};
		end
	end

	// commit arithmetic
	always_comb begin
		cnt_base = count_q;
		if (kind_q == dsrt_pkg::K_EXPIRED) begin
			cnt_base = (count_q >= {7'b0, rd_q.prefix}) ? count_q - {7'b0, rd_q.prefix} : '0;
		end
		cnt_new = first_q ? {7'b0, cbp_q} : cnt_base + {7'b0, cbp_q};
		take = first_q || (cnt_new == {7'b0, cbp_q});
		hop_dec = hop_in_q - 8'd1;
	end

	// faces and entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DN_SLOTS; i++) face_q[i] <= '0;
			count_q <= '0;
			hop_q <= '0;
			whole_q <= '0;
		end else if (cmd.commit) begin
			if (cmd_q == dsrt_pkg::CMD_CLEAR) begin
				for (int i = 0; i < DN_SLOTS; i++) face_q[i] <= '0;
				count_q <= '0;
				hop_q <= '0;
				whole_q <= '0;
			end else if (cmd_q == dsrt_pkg::CMD_INSERT && found_q) begin
				face_q[idx_q] <= face_in_q;
				if (kind_q == dsrt_pkg::K_FIRST) face_q[1] <= '0;
				count_q <= cnt_new;
				if (hop_in_q != 8'd0 && hop_dec > hop_q) hop_q <= hop_dec;
				if (rec_q > whole_q) whole_q <= rec_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			slot_index <= '0;
			dup_face <= '0;
			record_expiry <= '0;
			timer_rearm <= 1'b0;
			take_as_representative <= 1'b0;
			entry_expiry <= whole_q;
			tx_hop_limit <= hop_q;
			prefix_count <= count_q;
			if (cmd_q == dsrt_pkg::CMD_CLEAR) begin
				status <= dsrt_pkg::ST_CLEARED;
				entry_expiry <= '0;
				tx_hop_limit <= '0;
				prefix_count <= '0;
			end else if (cmd_q == dsrt_pkg::CMD_DUP) begin
				if (found_q && kind_q == dsrt_pkg::K_DUP) begin
					status <= dsrt_pkg::ST_DUP;
					dup_face <= cur_face;
				end else begin
					status <= dsrt_pkg::ST_NODUP;
				end
			end else if (!found_q) begin
				status <= dsrt_pkg::ST_FULL;
			end else begin
				status <= (kind_q == dsrt_pkg::K_REFRESH) ? dsrt_pkg::ST_REFRESH
					: dsrt_pkg::ST_NEW;
				slot_index <= 4'(idx_q);
				record_expiry <= rec_q;
				take_as_representative <= take;
				prefix_count <= cnt_new;
				if (hop_in_q != 8'd0 && hop_dec > hop_q) tx_hop_limit <= hop_dec;
				if (rec_q > whole_q) begin
					entry_expiry <= rec_q;
					timer_rearm <= 1'b1;
				end
			end
		end
	end

endmodule

/* hw/rtl/downstream_record_table_unit.sv */
// ----------------------------------------------------------------------------
// Downstream record table unit
// Downstream record slots of one pending-interest entry with insert,
// duplicate-nonce check and clear requests.
// ----------------------------------------------------------------------------
// An insert or duplicate check walks the slots in order from the first until a
// slot decides it or the last slot is reached; the walk inspects one slot per
// cycle through the single read port of the record memory, then the result is
// committed. A clear walks no slots and goes on to its commit. The unit takes
// one request at a time and is ready again the cycle after the commit; an unused
// command code is dropped without a result and leaves the unit ready again. A new
// request is accepted as soon as the previous result is committed to the output
// register, even if that result is still waiting to be taken; a waiting result
// holds the commit of the next one.
// Configuration writes are always ready and must happen while the unit is idle.
module downstream_record_table_unit #(
	parameter int DN_SLOTS = dsrt_pkg::DN_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dsrt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dsrt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     cmd,
	input  logic [15:0]                    face,
	input  logic [31:0]                    nonce,
	input  logic                           can_be_prefix,
	input  logic [31:0]                    lifetime_ms,
	input  logic [7:0]                     hop_limit,
	input  logic [61:0]                    now_ticks,
	input  logic [63:0]                    token,
	input  logic [7:0]                     cong_mark,
	input  logic                           first_interest,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     status,
	output logic [3:0]                     slot_index,
	output logic [15:0]                    dup_face,
	output logic [61:0]                    record_expiry,
	output logic [61:0]                    entry_expiry,
	output logic                           timer_rearm,
	output logic                           take_as_representative,
	output logic [7:0]                     tx_hop_limit,
	output logic [7:0]                     prefix_count
);

	dsrt_pkg::dp_cmd_t  dp_cmd;
	dsrt_pkg::dp_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	// sequencer
	dsrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// storage and arithmetic
	dsrt_dp #(.DN_SLOTS(DN_SLOTS)) u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (dp_cmd),
		.stat                   (dp_stat),
		.cfg_valid              (cfg_valid),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.cmd_in                 (cmd),
		.face                   (face),
		.nonce                  (nonce),
		.can_be_prefix          (can_be_prefix),
		.lifetime_ms            (lifetime_ms),
		.hop_limit              (hop_limit),
		.now_ticks              (now_ticks),
		.token                  (token),
		.cong_mark              (cong_mark),
		.first_interest         (first_interest),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.status                 (status),
		.slot_index             (slot_index),
		.dup_face               (dup_face),
		.record_expiry          (record_expiry),
		.entry_expiry           (entry_expiry),
		.timer_rearm            (timer_rearm),
		.take_as_representative (take_as_representative),
		.tx_hop_limit           (tx_hop_limit),
		.prefix_count           (prefix_count)
	);

`ifndef SYNTHESIS
	// busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("unit ready right after accepting a request");

	// a full table produces no record
	a_full_no_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dsrt_pkg::ST_FULL |-> !take_as_representative
		&& record_expiry == '0 && !timer_rearm)
		else $error("full result carries record data");

	// outgoing hop limit never reaches the maximum code
	a_hop_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tx_hop_limit != 8'hFF)
		else $error("hop limit out of range");

	// rearm only with a new or refreshed slot
	a_rearm_insert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timer_rearm |-> status == dsrt_pkg::ST_NEW
		|| status == dsrt_pkg::ST_REFRESH)
		else $error("timer rearm without insert");
`endif

endmodule

/* tb/sv/record_table_checker.sv */
// ----------------------------------------------------------------------------
// Downstream record table checker
// Watches the configuration, request and result channels, keeps its own copy
// of the slot table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module record_table_checker
	import dsrt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [1:0]           cmd,
	input  logic [15:0]          face,
	input  logic [31:0]          nonce,
	input  logic                 can_be_prefix,
	input  logic [31:0]          lifetime_ms,
	input  logic [7:0]           hop_limit,
	input  logic [61:0]          now_ticks,
	input  logic [63:0]          token,
	input  logic [7:0]           cong_mark,
	input  logic                 first_interest,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [2:0]           status,
	input  logic [3:0]           slot_index,
	input  logic [15:0]          dup_face,
	input  logic [61:0]          record_expiry,
	input  logic [61:0]          entry_expiry,
	input  logic                 timer_rearm,
	input  logic                 take_as_representative,
	input  logic [7:0]           tx_hop_limit,
	input  logic [7:0]           prefix_count,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot;
		logic [15:0] dup;
		logic [61:0] rec;
		logic [61:0] whole;
		logic        rearm;
		logic        take;
		logic [7:0]  hop;
		logic [7:0]  pcount;
	} table_result_t;

	localparam int NSLOT = DN_SLOTS_DEF;

	// shadow table and registers
	logic [15:0]      sh_face [NSLOT];
	logic [31:0]      sh_nonce [NSLOT];
	logic [61:0]      sh_expiry [NSLOT];
	logic             sh_prefix [NSLOT];
	logic [7:0]       sh_count;
	logic [7:0]       sh_hop;
	logic [61:0]      sh_whole;
	logic [CFG_W-1:0] sh_max_life;
	logic [CFG_W-1:0] sh_ticks;
	table_result_t    awaited_results [$];

	assign pending = awaited_results.size();

	function automatic void empty_table();
		for (int i = 0; i < NSLOT; i++) begin
			sh_face[i] = '0;
			sh_nonce[i] = '0;
			sh_expiry[i] = '0;
			sh_prefix[i] = 1'b0;
		end
		sh_count = '0;
		sh_hop = '0;
		sh_whole = '0;
	endfunction

	// compute the result of one request and update the shadow table
	function automatic table_result_t apply_request(
		logic [1:0] c, logic [15:0] f, logic [31:0] n, logic cbp, logic [31:0] life,
		logic [7:0] hop, logic [61:0] now, logic first);
		table_result_t r;
		int idx;
		logic refresh;
		logic found;
		logic [31:0] lt;
		logic [63:0] dur;
		logic [63:0] room;
		r = '0;
		idx = -1;
		refresh = 1'b0;
		found = 1'b0;
		if (c == CMD_CLEAR) begin
			empty_table();
			r.status = ST_CLEARED;
		end else if (c == CMD_DUP) begin
			r.status = ST_NODUP;
			for (int i = 0; i < NSLOT; i++) begin
				if (!found && sh_face[i] == '0) begin
					found = 1'b1;
				end else if (!found && sh_face[i] != f && sh_nonce[i] == n) begin
					r.dup = sh_face[i];
					r.status = ST_DUP;
					found = 1'b1;
				end
			end
		end else begin
			// walk slots in order; take the first with the same face, empty or expired
			if (sh_face[0] == '0) begin
				sh_face[1] = '0;
				sh_face[0] = f;
				idx = 0;
			end else begin
				for (int i = 0; i < NSLOT; i++) begin
					if (idx < 0) begin
						if (sh_face[i] == f) begin
							refresh = 1'b1;
							idx = i;
						end else if (sh_face[i] == '0) begin
							sh_face[i] = f;
							idx = i;
						end else if (sh_expiry[i] < now) begin
							sh_count = (sh_count >= sh_prefix[i]) ? sh_count - sh_prefix[i] : '0;
							sh_face[i] = f;
							idx = i;
						end
					end
				end
			end
			if (idx < 0) begin
				r.status = ST_FULL;
			end else begin
				lt = (life < sh_max_life) ? life : sh_max_life;
				dur = 64'(lt) * 64'(sh_ticks);
				room = 64'(TIME_MAX) - 64'(now);
				r.rec = (dur > room) ? TIME_MAX : 62'(64'(now) + dur);
				sh_prefix[idx] = cbp;
				sh_nonce[idx] = n;
				sh_expiry[idx] = r.rec;
				if (hop > 0 && hop - 8'd1 > sh_hop)
					sh_hop = hop - 8'd1;
				if (first) begin
					sh_count = {7'd0, cbp};
					r.take = 1'b1;
				end else begin
					sh_count = sh_count + cbp;
					r.take = (sh_count == {7'd0, cbp});
				end
				if (r.rec > sh_whole) begin
					sh_whole = r.rec;
					r.rearm = 1'b1;
				end
				r.status = refresh ? ST_REFRESH : ST_NEW;
				r.slot = idx[3:0];
			end
		end
		r.whole = sh_whole;
		r.hop = sh_hop;
		r.pcount = sh_count;
		return r;
	endfunction

	// follow the channels: results first, then new requests
	always @(posedge clk or negedge arst_n) begin
		table_result_t got;
		table_result_t want;
		if (!arst_n) begin
			empty_table();
			sh_max_life <= MAX_LIFE_RST;
			sh_ticks <= TICKS_RST;
			awaited_results.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MAX_LIFE)
					sh_max_life <= cfg_data;
				else if (cfg_index == REG_TICKS)
					sh_ticks <= cfg_data;
			end
			if (out_valid && out_ready) begin
				got = '{status, slot_index, dup_face, record_expiry, entry_expiry,
					timer_rearm, take_as_representative, tx_hop_limit, prefix_count};
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch st %0d/%0d slot %0d/%0d dup %h/%h rec %h/%h",
							$time, want.status, got.status, want.slot, got.slot,
							want.dup, got.dup, want.rec, got.rec);
						$display("%0t:   whole %h/%h rearm %b/%b take %b/%b hop %0d/%0d pc %0d/%0d",
							$time, want.whole, got.whole, want.rearm, got.rearm,
							want.take, got.take, want.hop, got.hop, want.pcount, got.pcount);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && in_ready && cmd != 2'd3)
				awaited_results.push_back(apply_request(cmd, face, nonce, can_be_prefix,
					lifetime_ms, hop_limit, now_ticks, first_interest));
		end
	end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Downstream record table testbench
// Drives directed and random insert, duplicate-nonce and clear requests over
// several register settings with random idling on both sides; a checker
// predicts every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import dsrt_pkg::*;

	localparam int WATCH_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           cmd;
	logic [15:0]          face;
	logic [31:0]          nonce;
	logic                 can_be_prefix;
	logic [31:0]          lifetime_ms;
	logic [7:0]           hop_limit;
	logic [61:0]          now_ticks;
	logic [63:0]          token;
	logic [7:0]           cong_mark;
	logic                 first_interest;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           status;
	logic [3:0]           slot_index;
	logic [15:0]          dup_face;
	logic [61:0]          record_expiry;
	logic [61:0]          entry_expiry;
	logic                 timer_rearm;
	logic                 take_as_representative;
	logic [7:0]           tx_hop_limit;
	logic [7:0]           prefix_count;
	int                   errors;
	int                   pending;
	int                   idle_cycles;
	int                   cycle_no;
	logic                 steady;
	logic [61:0]          arrival_clock;

	downstream_record_table_unit dut (.*);
	record_table_checker checker_i (.*);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// random gap: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// hang check: end the run when nothing moves
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random stalls and one long hold-off
	initial begin
		int hold;
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && cycle_no > 3000) begin
				held = 1'b1;
				out_ready = 1'b0;
				for (hold = 0; hold < 400; hold++)
					@(negedge clk);
			end
			hold = pick_gap();
			if (hold == 0) begin
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b0;
				repeat (hold) @(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	// send one request and wait for its handshake
	task automatic send_request(logic [1:0] c, logic [15:0] f, logic [31:0] n, logic cbp,
		logic [31:0] life, logic [7:0] hop, logic [61:0] now, logic first);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = c;
		face = f;
		nonce = n;
		can_be_prefix = cbp;
		lifetime_ms = life;
		hop_limit = hop;
		now_ticks = now;
		token = {$urandom, $urandom};
		cong_mark = 8'($urandom);
		first_interest = first;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// write one register once every result is out
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// random requests with pooled faces and nonces for deep table states
	task automatic random_phase(int count);
		logic [1:0]  c;
		logic [15:0] f;
		logic [31:0] n;
		logic [31:0] life;
		int r;
		for (int k = 0; k < count; k++) begin
			steady = (k % 200) < 30;
			r = $urandom_range(0, 99);
			c = (r < 5) ? CMD_CLEAR : (r < 30) ? CMD_DUP : CMD_INSERT;
			f = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535))
				: 16'($urandom_range(1, 22));
			n = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 15));
			r = $urandom_range(0, 99);
			life = (r < 5) ? $urandom : (r < 10) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 60));
			r = $urandom_range(0, 99);
			if (r < 2)
				arrival_clock = 62'({$urandom, $urandom});
			else if (r < 3)
				arrival_clock = TIME_MAX;
			else
				arrival_clock = arrival_clock + 62'($urandom_range(0, 30_000_000));
			send_request(c, f, n, 1'($urandom), life, 8'($urandom_range(1, 255)),
				arrival_clock, $urandom_range(0, 9) == 0);
		end
		in_valid = 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_CLEAR;
		face = 16'd1;
		nonce = '0;
		can_be_prefix = 1'b0;
		lifetime_ms = '0;
		hop_limit = 8'd1;
		now_ticks = '0;
		token = '0;
		cong_mark = '0;
		first_interest = 1'b0;
		steady = 1'b0;
		arrival_clock = '0;
		cycle_no = 0;
		idle_cycles = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: fill, refresh, duplicate, saturation, full, expired reuse
		send_request(CMD_CLEAR, 16'd5, 32'd0, 1'b0, 32'd0, 8'd1, 62'd0, 1'b0);
		send_request(CMD_INSERT, 16'd1, 32'hAAAA_5555, 1'b1, 32'd0, 8'd1, 62'd0, 1'b1);
		send_request(CMD_INSERT, 16'd2, 32'h5555_AAAA, 1'b1, 32'hFFFF_FFFF, 8'd255,
			62'd0, 1'b0);
		send_request(CMD_INSERT, 16'd1, 32'h1234_0000, 1'b0, 32'd10, 8'd7, 62'd0, 1'b0);
		send_request(CMD_DUP, 16'd2, 32'h1234_0000, 1'b0, 32'd0, 8'd1, 62'd0, 1'b0);
		send_request(CMD_DUP, 16'd1, 32'h1234_0000, 1'b0, 32'd0, 8'd1, 62'd0, 1'b0);
		send_request(CMD_DUP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 8'd1, TIME_MAX, 1'b0);
		send_request(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd500, 8'd128,
			TIME_MAX, 1'b0);
		for (int i = 4; i <= 16; i++)
			send_request(CMD_INSERT, 16'(i), 32'(i), 1'(i), 32'd1000, 8'(i), 62'd0, 1'b0);
		send_request(CMD_INSERT, 16'd17, 32'd17, 1'b1, 32'd5, 8'd1, 62'd5, 1'b0);
		send_request(CMD_INSERT, 16'd18, 32'd18, 1'b0, 32'd5, 8'd1, 62'h3FFF_0000_0000_0000,
			1'b0);
		send_request(CMD_DUP, 16'd3, 32'd18, 1'b0, 32'd0, 8'd1, 62'd0, 1'b0);
		in_valid = 1'b0;

		// random phases over register settings
		random_phase(400);
		write_reg(REG_MAX_LIFE, 32'd1);
		write_reg(REG_TICKS, 32'd1);
		arrival_clock = '0;
		random_phase(350);
		write_reg(REG_MAX_LIFE, 32'hFFFF_FFFF);
		write_reg(REG_TICKS, 32'hFFFF_FFFF);
		random_phase(350);
		write_reg(REG_MAX_LIFE, 32'd40);
		write_reg(REG_TICKS, 32'd250_000);
		write_reg(2'd3, 32'hFFFF_FFFF);
		random_phase(400);
		write_reg(REG_MAX_LIFE, MAX_LIFE_RST);
		write_reg(REG_TICKS, TICKS_RST);
		random_phase(380);

		// drain and give the verdict
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
